/* src/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // default width of the decoded payload length
  localparam int unsigned LengthBitsDefault = 64;

  // parser phases
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_HDR0 = 3'd0;
  localparam logic [PhaseW-1:0] PH_HDR1 = 3'd1;
  localparam logic [PhaseW-1:0] PH_EXT  = 3'd2;
  localparam logic [PhaseW-1:0] PH_KEY  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd4;

  // header byte fields
  localparam logic [7:0] FinBit     = 8'h80;
  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] Len7Mask   = 8'h7F;
  localparam logic [6:0] Len7Ext16  = 7'd126;
  localparam logic [6:0] Len7Ext64  = 7'd127;

  // extended length / key byte counts
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  // record kinds
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

endpackage

/* src/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a byte stream of WebSocket frames into header records and unmasked
// payload bytes.
// ----------------------------------------------------------------------------
// Takes one raw frame byte per cycle and parses FIN/opcode, mask flag, 7-bit
// length with optional 16- or 64-bit big-endian extension, and the 4-byte
// masking key. A header record (kind 0) goes out once the header is complete;
// each payload byte then goes out unmasked (kind 1), with last_of_frame on the
// final byte or on the header of an empty frame. Header bytes that do not
// complete the header give no result. Throughput is one byte per cycle: each
// byte is parsed in a single pass into the result register, and a new byte is
// taken whenever that register is empty or being drained in the same cycle.
// A result is valid in the cycle after its byte is accepted. The decoded length
// is kept modulo 2^LENGTH_BITS, with the top bit cleared if LENGTH_BITS > 63.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [3:0]  frame_opcode_o,
  output logic        final_flag_o,
  output logic        masked_flag_o,
  output logic [62:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o
);

  localparam int unsigned LW = LENGTH_BITS;
  // the top bit of a length wider than 63 bits is dropped
  localparam logic [LW-1:0] KeepMask =
    (LW > 63) ? {1'b0, {(LW-1){1'b1}}} : {LW{1'b1}};

  // parser state
  logic [wsfd_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [3:0]    ext_cnt_q, ext_cnt_d;
  logic          fin_q, fin_d;
  logic [3:0]    opcode_q, opcode_d;
  logic          masked_q, masked_d;
  logic [LW-1:0] accum_q, accum_d;
  logic [31:0]   key_q, key_d;
  logic [LW-1:0] left_q, left_d;
  logic [1:0]    key_idx_q, key_idx_d;

  // result register
  logic          ovalid_q, ovalid_d;
  logic          kind_q, kind_d;
  logic [3:0]    oopc_q, oopc_d;
  logic          ofin_q, ofin_d;
  logic          omask_q, omask_d;
  logic [62:0]   olen_q, olen_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          olast_q, olast_d;

  logic          in_fire;
  logic [6:0]    len7;
  logic [LW-1:0] len_cand;
  logic [LW-1:0] len_fin;
  logic [63:0]   len_ext;
  logic [3:0]    cnt_dec;
  logic [LW-1:0] left_dec;
  logic [4:0]    key_sh;
  logic [7:0]    key_byte;
  logic          emit_hdr;

  function automatic logic [6:0] Len7Mask7();
    return wsfd_pkg::Len7Mask[6:0];
  endfunction

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len7     = in_byte_i[6:0] & Len7Mask7();
  assign cnt_dec  = ext_cnt_q - 4'd1;
  assign key_sh   = {~key_idx_q, 3'b000};
  assign key_byte = masked_q ? key_q[key_sh +: 8] : 8'h00;
  assign left_dec = (left_q != '0) ? left_q - LW'(1) : left_q;

  // candidate length at the point where it becomes final
  always_comb begin
    if (phase_q == wsfd_pkg::PH_HDR1) begin
      len_cand = LW'(len7);
    end else if (phase_q == wsfd_pkg::PH_EXT) begin
      len_cand = {accum_q[LW-9:0], in_byte_i};
    end else begin
      len_cand = accum_q;
    end
  end
  assign len_fin = len_cand & KeepMask;
  assign len_ext = 64'(len_fin);

  always_comb begin
    phase_d   = phase_q;
    ext_cnt_d = ext_cnt_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    accum_d   = accum_q;
    key_d     = key_q;
    left_d    = left_q;
    key_idx_d = key_idx_q;
    emit_hdr  = 1'b0;

    ovalid_d = ovalid_q && !out_ready_i;
    kind_d   = kind_q;
    oopc_d   = oopc_q;
    ofin_d   = ofin_q;
    omask_d  = omask_q;
    olen_d   = olen_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;

    if (in_fire) begin
      case (phase_q)
        wsfd_pkg::PH_HDR0: begin
          fin_d    = |(in_byte_i & wsfd_pkg::FinBit);
          opcode_d = 4'(in_byte_i & wsfd_pkg::OpcodeMask);
          phase_d  = wsfd_pkg::PH_HDR1;
        end
        wsfd_pkg::PH_HDR1: begin
          masked_d = |(in_byte_i & wsfd_pkg::FinBit);
          accum_d  = '0;
          if (len7 == wsfd_pkg::Len7Ext16) begin
            ext_cnt_d = wsfd_pkg::Ext16Bytes;
            phase_d   = wsfd_pkg::PH_EXT;
          end else if (len7 == wsfd_pkg::Len7Ext64) begin
            ext_cnt_d = wsfd_pkg::Ext64Bytes;
            phase_d   = wsfd_pkg::PH_EXT;
          end else if (masked_d) begin
            accum_d   = len_cand;
            ext_cnt_d = wsfd_pkg::KeyBytes;
            phase_d   = wsfd_pkg::PH_KEY;
          end else begin
            emit_hdr = 1'b1;
          end
        end
        wsfd_pkg::PH_EXT: begin
          accum_d   = len_cand;
          ext_cnt_d = cnt_dec;
          if (cnt_dec == 4'd0) begin
            if (masked_q) begin
              ext_cnt_d = wsfd_pkg::KeyBytes;
              phase_d   = wsfd_pkg::PH_KEY;
            end else begin
              emit_hdr = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_d     = {key_q[23:0], in_byte_i};
          ext_cnt_d = cnt_dec;
          if (cnt_dec == 4'd0) begin
            emit_hdr = 1'b1;
          end
        end
        wsfd_pkg::PH_DATA: begin
          key_idx_d = key_idx_q + 2'd1;
          left_d    = left_dec;
          ovalid_d  = 1'b1;
          kind_d    = wsfd_pkg::KindPayload;
          oopc_d    = opcode_q;
          ofin_d    = fin_q;
          omask_d   = masked_q;
          olen_d    = '0;
          obyte_d   = in_byte_i ^ key_byte;
          olast_d   = (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_d = wsfd_pkg::PH_HDR0;
        end
      endcase

      if (emit_hdr) begin
        accum_d   = len_fin;
        left_d    = len_fin;
        key_idx_d = 2'd0;
        ovalid_d  = 1'b1;
        kind_d    = wsfd_pkg::KindHeader;
        oopc_d    = opcode_d;
        ofin_d    = fin_d;
        omask_d   = masked_d;
        olen_d    = len_ext[62:0];
        obyte_d   = 8'h00;
        olast_d   = (len_fin == '0);
        phase_d   = (len_fin == '0) ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsfd_pkg::PH_HDR0;
      ext_cnt_q <= '0;
      fin_q     <= 1'b0;
      opcode_q  <= '0;
      masked_q  <= 1'b0;
      accum_q   <= '0;
      key_q     <= '0;
      left_q    <= '0;
      key_idx_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ext_cnt_q <= ext_cnt_d;
      fin_q     <= fin_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      accum_q   <= accum_d;
      key_q     <= key_d;
      left_q    <= left_d;
      key_idx_q <= key_idx_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    oopc_q  <= oopc_d;
    ofin_q  <= ofin_d;
    omask_q <= omask_d;
    olen_q  <= olen_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o      = ovalid_q;
  assign kind_o           = kind_q;
  assign frame_opcode_o   = oopc_q;
  assign final_flag_o     = ofin_q;
  assign masked_flag_o    = omask_q;
  assign payload_length_o = olen_q;
  assign payload_byte_o   = obyte_q;
  assign last_of_frame_o  = olast_q;

  // among header records, only the header of an empty frame closes the frame
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == wsfd_pkg::KindHeader)
      |-> (last_of_frame_o == (payload_length_o == 63'd0)))
    else $error("header last_of_frame disagrees with length");

  // payload records carry no length
  a_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == wsfd_pkg::KindPayload) |-> (payload_length_o == 63'd0))
    else $error("payload record with nonzero length");

  // byte counter live while collecting extension or key
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsfd_pkg::PH_EXT || phase_q == wsfd_pkg::PH_KEY) |-> (ext_cnt_q != 4'd0))
    else $error("extension/key counter empty mid-header");

  // last payload byte returns to header parsing
  a_data_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == wsfd_pkg::PH_DATA && left_q == LW'(1))
      |=> (phase_q == wsfd_pkg::PH_HDR0 && out_valid_o && last_of_frame_o))
    else $error("frame did not end after its last byte");

endmodule
